FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every clk edge while rst is low.
`define ASSERT_DIS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Check prop on every clk edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

FILE: hw/rtl/bpc_pkg.sv
`timescale 1ns / 1ps

package bpc_pkg;

   localparam int unsigned ENTRY_W     = 4;
   localparam int unsigned TABLE_SLOTS = 10;
   localparam int unsigned TABLE_W     = ENTRY_W * TABLE_SLOTS;
   localparam int unsigned CSR_IDX_W   = 2;

   localparam logic [7:0] SPACE_CHAR = 8'd32;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LENGTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERM_TABLE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DECRYPT_MODE = 2'd2;

   localparam logic [3:0]         KEY_RESET     = 4'd1;
   localparam logic [TABLE_W-1:0] PERM_RESET    = 40'hA987654321;
   localparam logic               DECRYPT_RESET = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUILD,
      ST_EMIT,
      ST_OVF
   } state_type;

endpackage

FILE: hw/rtl/block_permutation_cipher_top.sv
`timescale 1ns / 1ps
// Columnar block transposition over a byte stream.
// req channel: one text byte per beat (tdata), tlast marks the final byte of a
// message. rsp channel: one output byte per beat; tlast marks the last beat
// caused by one input byte, tuser flags message end and a dropped space.
// Non-space bytes collect into blocks of key_length; spaces stay in place.
// A byte that does not complete a block, end the message or get dropped gives
// no beat, and the block is ready again in the next cycle. A completed block
// passes an accept step, then the table walk (one table entry per cycle through
// the shared compare/index unit), then one beat per held byte. A message-end
// flush of a partial block skips the walk. A dropped space adds one beat.
// req_tready is low from the accept of a completing byte until its last beat
// sits in the output register; that register holds while rsp_tready is low,
// and the emit sequencer waits on it. The held run lives in a memory with
// registered reads, so emission streams one beat per cycle when unstalled.
// Reset (synchronous) restores key_length 1, the identity table, encrypt mode,
// and empties the held run; no clearing pass is needed. Configuration must be
// written through csr_* only while idle; the block itself does not enforce this.
module block_permutation_cipher_top #(
   parameter int unsigned MAX_KEY   = 10,
   parameter int unsigned POS_DEPTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] in_char
   input  logic                              req_tlast,   // msg_last
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,   // [7:0] out_char
   output logic                              rsp_tlast,   // run_last
   output logic [1:0]                        rsp_tuser,   // [0] msg_end, [1] overflow
   input  logic                              csr_wr_en,
   input  logic [bpc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bpc_pkg::TABLE_W-1:0]       csr_wdata
);
   import bpc_pkg::*;

   localparam int unsigned IDX_W = $clog2(MAX_KEY);
   localparam int unsigned HC_W  = $clog2(MAX_KEY + 1);
   localparam int unsigned PA_W  = $clog2(POS_DEPTH);
   localparam int unsigned HP_W  = $clog2(POS_DEPTH + 1);
   localparam int unsigned SUM_W = HP_W + 2;

   state_type state_ff, state_in;

   logic [3:0]         key_ff;
   logic [TABLE_W-1:0] perm_ff;
   logic               decrypt_ff;

   logic [HP_W-1:0]  hp_ff, hp_in;
   logic [HC_W-1:0]  hc_ff, hc_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic [PA_W-1:0]  pos_ff, pos_in;
   logic             last_ff, last_in;
   logic             drop_ff, drop_in;
   logic             perm_en_ff, perm_en_in;

   logic [7:0]       char_store_ff [MAX_KEY];
   logic [IDX_W-1:0] src_ff [MAX_KEY];
   logic [7:0]       mark_mem [POS_DEPTH];
   logic [7:0]       mark_q_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_char_ff, rsp_char_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       rsp_end_ff, rsp_end_in;
   logic       rsp_ovf_ff, rsp_ovf_in;
   logic       rsp_load;

   // accept-side decode
   logic [4:0]       klen5;
   logic [HC_W-1:0]  keff;
   logic [HC_W-1:0]  need;
   logic             accept;
   logic             is_space;
   logic             space_fit;
   logic             char_fit;
   logic             store;
   logic             char_wr;
   logic [HP_W-1:0]  hp_next;
   logic [HC_W-1:0]  hc_next;
   logic             complete;

   // table walk
   logic [TABLE_W-1:0] tbl_sh;
   logic [ENTRY_W-1:0] entry;
   logic               entry_ok;
   logic               src_wr;
   logic [IDX_W-1:0]   src_wr_idx;
   logic [IDX_W-1:0]   src_wr_val;

   // emit
   logic       load_ok;
   logic       take_perm;
   logic       final_beat;
   logic [7:0] emit_char;

   assign accept   = req_tvalid && req_tready;
   assign is_space = (req_tdata == SPACE_CHAR);

   always_comb begin
      klen5 = {1'b0, key_ff};
      if (key_ff == 4'd0) begin
         keff = HC_W'(1);
      end else if (klen5 > 5'(MAX_KEY)) begin
         keff = HC_W'(MAX_KEY);
      end else begin
         keff = HC_W'(klen5);
      end
      need      = (keff > hc_ff) ? (keff - hc_ff) : HC_W'(1);
      space_fit = (SUM_W'(hp_ff) + SUM_W'(1) + SUM_W'(need)) <= SUM_W'(POS_DEPTH);
      char_fit  = (hp_ff < HP_W'(POS_DEPTH)) && (hc_ff < HC_W'(MAX_KEY));
      store     = is_space ? space_fit : char_fit;
      char_wr   = !is_space && char_fit;
      hp_next   = hp_ff + HP_W'(store);
      hc_next   = hc_ff + HC_W'(char_wr);
      complete  = !is_space && ((hc_next >= keff) || (hp_next >= HP_W'(POS_DEPTH)));
   end

   // one table entry per cycle through the shared compare/index unit
   always_comb begin
      tbl_sh   = perm_ff >> {cnt_ff, 2'b00};
      entry    = (5'(cnt_ff) < 5'(TABLE_SLOTS)) ? tbl_sh[ENTRY_W-1:0] : '0;
      entry_ok = (entry != '0) && (5'(entry) <= 5'(hc_ff));
      src_wr   = (state_ff == ST_BUILD) && perm_en_ff && entry_ok;
      if (decrypt_ff) begin
         src_wr_idx = IDX_W'(entry - ENTRY_W'(1));
         src_wr_val = cnt_ff;
      end else begin
         src_wr_idx = cnt_ff;
         src_wr_val = IDX_W'(entry - ENTRY_W'(1));
      end
   end

   always_comb begin
      load_ok    = !rsp_valid_ff || rsp_tready;
      take_perm  = perm_en_ff && (mark_q_ff != SPACE_CHAR);
      emit_char  = take_perm ? char_store_ff[src_ff[slot_ff]] : mark_q_ff;
      final_beat = (HP_W'(pos_ff) + HP_W'(1)) == hp_ff;
   end

   always_comb begin
      state_in    = state_ff;
      hp_in       = hp_ff;
      hc_in       = hc_ff;
      cnt_in      = cnt_ff;
      slot_in     = slot_ff;
      pos_in      = pos_ff;
      last_in     = last_ff;
      drop_in     = drop_ff;
      perm_en_in  = perm_en_ff;
      rsp_load    = 1'b0;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      rsp_end_in  = rsp_end_ff;
      rsp_ovf_in  = rsp_ovf_ff;
      req_tready  = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               hp_in      = hp_next;
               hc_in      = hc_next;
               last_in    = req_tlast;
               drop_in    = is_space && !space_fit;
               perm_en_in = complete;
               cnt_in     = '0;
               slot_in    = '0;
               pos_in     = '0;
               if ((complete || req_tlast) && (hp_next != '0)) begin
                  state_in = ST_BUILD;
               end else if (is_space && !space_fit) begin
                  state_in = ST_OVF;
               end
            end
         end
         ST_BUILD: begin
            // a plain flush needs no walk, only the read turnaround
            if (!perm_en_ff || ((HC_W'(cnt_ff) + HC_W'(1)) == hc_ff)) begin
               state_in = ST_EMIT;
            end else begin
               cnt_in = cnt_ff + IDX_W'(1);
            end
         end
         ST_EMIT: begin
            if (load_ok) begin
               rsp_load    = 1'b1;
               rsp_char_in = emit_char;
               rsp_last_in = final_beat && !drop_ff;
               rsp_end_in  = final_beat && !drop_ff && last_ff;
               rsp_ovf_in  = 1'b0;
               if (final_beat) begin
                  hp_in    = '0;
                  hc_in    = '0;
                  slot_in  = '0;
                  pos_in   = '0;
                  state_in = drop_ff ? ST_OVF : ST_IDLE;
               end else begin
                  pos_in  = pos_ff + PA_W'(1);
                  slot_in = slot_ff + IDX_W'(take_perm);
               end
            end
         end
         ST_OVF: begin
            if (load_ok) begin
               rsp_load    = 1'b1;
               rsp_char_in = '0;
               rsp_last_in = 1'b1;
               rsp_end_in  = last_ff;
               rsp_ovf_in  = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         key_ff       <= KEY_RESET;
         perm_ff      <= PERM_RESET;
         decrypt_ff   <= DECRYPT_RESET;
         hp_ff        <= '0;
         hc_ff        <= '0;
         cnt_ff       <= '0;
         slot_ff      <= '0;
         pos_ff       <= '0;
         last_ff      <= 1'b0;
         drop_ff      <= 1'b0;
         perm_en_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hp_ff        <= hp_in;
         hc_ff        <= hc_in;
         cnt_ff       <= cnt_in;
         slot_ff      <= slot_in;
         pos_ff       <= pos_in;
         last_ff      <= last_in;
         drop_ff      <= drop_in;
         perm_en_ff   <= perm_en_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_KEY_LENGTH:   key_ff     <= csr_wdata[3:0];
               CSR_PERM_TABLE:   perm_ff    <= csr_wdata;
               CSR_DECRYPT_MODE: decrypt_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_end_ff  <= rsp_end_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      if (accept && char_wr) begin
         char_store_ff[hc_ff[IDX_W-1:0]] <= req_tdata;
      end
      // start every walk from the identity map
      if (accept) begin
         for (int i = 0; i < MAX_KEY; i++) begin
            src_ff[i] <= IDX_W'(i);
         end
      end else if (src_wr) begin
         src_ff[src_wr_idx] <= src_wr_val;
      end
   end

   // held run memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (accept && store) begin
         mark_mem[hp_ff[PA_W-1:0]] <= req_tdata;
      end
      mark_q_ff <= mark_mem[pos_in];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_ovf_ff, rsp_end_ff};

endmodule

FILE: hw/rtl/bpc_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bpc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic [1:0] rsp_tuser
);

   logic [10:0] rsp_beat;

   assign rsp_beat = {rsp_tuser, rsp_tlast, rsp_tdata};

   // a stalled beat holds
   `ASSERT_DIS(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_beat))

   // a dropped-space beat carries a zero byte and closes its input's run
   `ASSERT_DIS(a_ovf_beat, clock, reset, rsp_tvalid && rsp_tuser[1] |-> (rsp_tdata == 8'd0) && rsp_tlast)

   // message end only on the last beat of an input
   `ASSERT_DIS(a_end_last, clock, reset, rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)

   // no beat right after reset
   `ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid)

endmodule

bind block_permutation_cipher_top bpc_checker u_bpc_checker (.*);

FILE: bench/tb_block_permutation_cipher_top.sv
`timescale 1ns / 1ps

module tb_block_permutation_cipher_top;
   import bpc_pkg::*;

   localparam int MAX_KEY      = 10;
   localparam int POS_DEPTH    = 32;
   localparam int DRAIN_CYCLES = 64;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_msg;
   } text_beat_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       run_last;
      logic       msg_end;
      logic       overflow;
   } cipher_out_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata  = '0;   // [7:0] in_char
   logic                 req_tlast  = 1'b0; // msg_last
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;         // [7:0] out_char
   logic                 rsp_tlast;         // run_last
   logic [1:0]           rsp_tuser;         // [0] msg_end, [1] overflow
   logic                 csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [TABLE_W-1:0]   csr_wdata  = '0;

   // Shadow copy of the block: settings and the held run
   logic [3:0]         key_reg     = KEY_RESET;
   logic [TABLE_W-1:0] perm_reg    = PERM_RESET;
   logic               decrypt_reg = DECRYPT_RESET;
   logic [7:0]         blk_chars [MAX_KEY];
   logic [7:0]         run_bytes [POS_DEPTH];
   int                 run_len     = 0;
   int                 blk_len     = 0;

   text_beat_type  plain_beats[$];
   cipher_out_type cipher_stream[$];

   bit steady_flow   = 1'b0;
   bit req_taken     = 1'b0;
   bit rsp_taken     = 1'b0;
   int req_wait      = 0;
   int rsp_wait      = 0;
   int mismatch_count = 0;
   int bytes_sent    = 0;
   int bytes_checked = 0;
   int overflow_seen = 0;
   int msg_ends_seen = 0;

   block_permutation_cipher_top #(
      .MAX_KEY   (MAX_KEY),
      .POS_DEPTH (POS_DEPTH)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic int draw_gap();
      return steady_flow ? 0 : $urandom_range(0, 13);
   endfunction

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      $display("mismatch: %s", msg);
   endtask

   // Emit the held run; permute the block when it completed
   task automatic flush_run(input bit permute);
      int src [MAX_KEY];
      int n;
      int slot;
      int e;
      int s;
      cipher_out_type r;
      n = blk_len;
      slot = 0;
      for (int j = 0; j < MAX_KEY; j++) src[j] = j;
      if (permute) begin
         for (int j = 0; j < n && j < MAX_KEY; j++) begin
            e = int'(perm_reg[4*j +: 4]);
            if (e >= 1 && e <= n) begin
               if (decrypt_reg) src[e-1] = j;
               else src[j] = e - 1;
            end
         end
      end
      for (int p = 0; p < run_len; p++) begin
         r = '0;
         r.ch = run_bytes[p];
         if (permute && run_bytes[p] != SPACE_CHAR) begin
            s = (slot < MAX_KEY) ? src[slot] : 0;
            if (s >= MAX_KEY) s = 0;
            r.ch = blk_chars[s];
            slot++;
         end
         cipher_stream.push_back(r);
      end
      run_len = 0;
      blk_len = 0;
   endtask

   task automatic encipher_byte(input logic [7:0] ch, input logic end_msg);
      int k;
      int need;
      int had;
      bit dropped;
      bit complete;
      cipher_out_type r;
      k = (key_reg == 0) ? 1 : (key_reg > MAX_KEY) ? MAX_KEY : int'(key_reg);
      had = cipher_stream.size();
      dropped = 1'b0;
      complete = 1'b0;
      if (ch == SPACE_CHAR) begin
         // keep room for the characters the block still needs
         need = (k > blk_len) ? k - blk_len : 1;
         if (run_len + 1 + need <= POS_DEPTH) begin
            run_bytes[run_len] = ch;
            run_len++;
         end else begin
            dropped = 1'b1;
         end
      end else begin
         if (run_len < POS_DEPTH && blk_len < MAX_KEY) begin
            run_bytes[run_len] = ch;
            run_len++;
            blk_chars[blk_len] = ch;
            blk_len++;
         end
         complete = (blk_len >= k) || (run_len >= POS_DEPTH);
      end
      if (complete) flush_run(1'b1);
      else if (end_msg) flush_run(1'b0);
      if (dropped) begin
         r = '0;
         r.overflow = 1'b1;
         cipher_stream.push_back(r);
      end
      if (cipher_stream.size() > had) begin
         r = cipher_stream.pop_back();
         r.run_last = 1'b1;
         r.msg_end = end_msg;
         cipher_stream.push_back(r);
      end
   endtask

   task automatic queue_byte(input logic [7:0] ch, input logic end_msg);
      text_beat_type b;
      b.ch = ch;
      b.end_msg = end_msg;
      plain_beats.push_back(b);
   endtask

   task automatic queue_run(input int count, input int space_pct, input bit close);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < space_pct)
            queue_byte(SPACE_CHAR, close && i == count - 1);
         else
            queue_byte(8'($urandom_range(0, 255)), close && i == count - 1);
      end
   endtask

   // Hold until the sender is empty and every byte has come back, then let the
   // block finish any work that gives no beat
   task automatic settle();
      while (plain_beats.size() != 0 || req_tvalid || cipher_stream.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_settings(input logic [3:0] key, input logic [TABLE_W-1:0] perm_bits,
                                input logic dec);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_KEY_LENGTH;
      csr_wdata <= TABLE_W'(key);
      @(negedge clock);
      csr_index <= CSR_PERM_TABLE;
      csr_wdata <= perm_bits;
      @(negedge clock);
      csr_index <= CSR_DECRYPT_MODE;
      csr_wdata <= TABLE_W'(dec);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      key_reg = key;
      perm_reg = perm_bits;
      decrypt_reg = dec;
   endtask

   // Sender: one beat at a time, with a drawn gap after each accepted beat
   always @(negedge clock) begin
      text_beat_type b;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (req_taken) begin
            req_taken = 1'b0;
            req_wait = draw_gap();
         end
         if (req_wait > 0) begin
            req_wait--;
            req_tvalid <= 1'b0;
         end else if (plain_beats.size() != 0) begin
            b = plain_beats.pop_front();
            req_tdata <= b.ch;
            req_tlast <= b.end_msg;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: stall a drawn number of cycles after each accepted beat
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            rsp_wait = draw_gap();
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cipher_out_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            bytes_sent++;
            encipher_byte(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_taken = 1'b1;
            bytes_checked++;
            if (rsp_tuser[1]) overflow_seen++;
            if (rsp_tuser[0]) msg_ends_seen++;
            if (cipher_stream.size() == 0) begin
               flag_mismatch($sformatf("unexpected beat data %02h tlast %b tuser %b",
                                       rsp_tdata, rsp_tlast, rsp_tuser));
            end else begin
               want = cipher_stream.pop_front();
               if (rsp_tdata !== want.ch)
                  flag_mismatch($sformatf("out_char got %02h want %02h", rsp_tdata, want.ch));
               if (rsp_tlast !== want.run_last)
                  flag_mismatch($sformatf("run_last got %b want %b", rsp_tlast, want.run_last));
               if (rsp_tuser[0] !== want.msg_end)
                  flag_mismatch($sformatf("msg_end got %b want %b", rsp_tuser[0], want.msg_end));
               if (rsp_tuser[1] !== want.overflow)
                  flag_mismatch($sformatf("overflow got %b want %b", rsp_tuser[1],
                                          want.overflow));
            end
         end
      end
   end

   initial begin
      #10ms;
      $display("[block_permutation_cipher_top] ERROR");
      $finish;
   end

   initial begin
      int                 count;
      int                 m;
      int                 k;
      int                 j;
      int                 t;
      int                 order [MAX_KEY];
      bit                 drained;
      logic [3:0]         key;
      logic [TABLE_W-1:0] perm_bits;
      logic               dec;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: one-character blocks, identity table
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(SPACE_CHAR, 1'b0);
      queue_byte(8'h41, 1'b0);
      queue_byte(SPACE_CHAR, 1'b1);
      settle();

      // four-character blocks, one entry out of range, partial block at message end
      load_settings(4'd4, 40'hF000001942, 1'b0);
      queue_byte(8'h61, 1'b0);
      queue_byte(8'h62, 1'b0);
      queue_byte(SPACE_CHAR, 1'b0);
      queue_byte(8'h63, 1'b0);
      queue_byte(8'h64, 1'b0);
      queue_byte(8'h78, 1'b0);
      queue_byte(8'h79, 1'b1);
      settle();

      // inverse with duplicate entries: later entry wins, unwritten slots map to self
      load_settings(4'd3, 40'h0000000022, 1'b1);
      queue_byte(8'h70, 1'b0);
      queue_byte(8'h71, 1'b0);
      queue_byte(8'h72, 1'b0);
      queue_byte(SPACE_CHAR, 1'b1);
      settle();

      drained = 1'b0;
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: key = 4'd10;
            1: key = 4'd0;
            2: key = 4'd15;
            3: key = 4'd1;
            default: key = 4'($urandom_range(0, 15));
         endcase
         k = (key == 0) ? 1 : (key > MAX_KEY) ? MAX_KEY : int'(key);
         for (int i = 0; i < MAX_KEY; i++) order[i] = i + 1;
         for (int i = k - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
         end
         perm_bits = {8'($urandom), $urandom};
         if (p == 4) perm_bits = '1;
         else if (p == 5) perm_bits = '0;
         else if ($urandom_range(0, 3) != 0)
            for (int i = 0; i < k; i++) perm_bits[4*i +: 4] = 4'(order[i]);
         dec = (p < 4) ? p[0] : 1'($urandom_range(0, 1));
         steady_flow = (p == 2 || p == 6);
         load_settings(key, perm_bits, dec);

         count = 0;
         while (count < 14) begin
            m = $urandom_range(0, 9);
            if (m < 2) begin
               // flood of spaces to run the position buffer out of room
               t = $urandom_range(18, 30);
               m = $urandom_range(0, 12);
               queue_run(t, 100, m == 0);
               queue_run(m, 20, 1'b1);
               count += t + m;
            end else if (m == 2) begin
               queue_run(1, 30, 1'b1);
               count += 1;
            end else begin
               m = $urandom_range(2, 16);
               queue_run(m, 20, 1'b1);
               count += m;
            end
            if (p == 3 && !drained) begin
               settle();
               drained = 1'b1;
            end
         end
         settle();
      end

      $display("run covered %0d input bytes over 11 settings, %0d output bytes checked",
               bytes_sent, bytes_checked);
      $display("%0d dropped-space flags and %0d message ends seen", overflow_seen,
               msg_ends_seen);
      if (mismatch_count == 0)
         $display("[block_permutation_cipher_top] OK");
      else
         $display("[block_permutation_cipher_top] ERROR");
      $finish;
   end

endmodule
